### rtl/hpd_pkg.sv
`timescale 1ns / 1ps
package hpd_pkg;

  localparam int HEADING_W = 20;
  localparam int ERR_W     = HEADING_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int GAIN_W    = 16;
  localparam int CF_W      = 11;
  localparam int SUM_W     = 32;
  localparam int DRIVE_W   = 8;

  localparam int TP_W  = GAIN_W + 1 + ERR_W;
  localparam int TI_W  = GAIN_W + 1 + SUM_W;
  localparam int TD_W  = GAIN_W + 1 + DIFF_W;
  localparam int TOT_W = TI_W + 2;
  localparam int PSHIFT = 12;
  localparam int PW_W  = TOT_W - PSHIFT;

  // power is limited to +-2^16 ahead of the drive stage; any larger value
  // is clamped to that limit before the drives are formed
  localparam int PWR_W   = 18;
  localparam int PWR_LIM = 65536;
  localparam int RPROD_W = PWR_W + CF_W;
  localparam int RSHIFT  = 8;
  localparam int RSH_W   = RPROD_W - RSHIFT;
  localparam int DRIVE_MAX = 127;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_GAIN_P  = 3'd1,
    REG_GAIN_I  = 3'd2,
    REG_GAIN_D  = 3'd3,
    REG_CURVE_F = 3'd4,
    REG_CURVE_M = 3'd5,
    REG_GO_FWD  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [HEADING_W-1:0] target_heading;
    logic [GAIN_W-1:0]           gain_p;
    logic [GAIN_W-1:0]           gain_i;
    logic [GAIN_W-1:0]           gain_d;
    logic signed [CF_W-1:0]      curve_factor;
    logic                        curve_mode;
    logic                        go_forward;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic pow;
    logic drv;
  } cmd_t;

endpackage

### rtl/hpd_if.sv
`timescale 1ns / 1ps
interface hpd_in_if import hpd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [HEADING_W-1:0] heading;
  logic                        restart;

  modport source (output valid, output heading, output restart, input ready);
  modport sink   (input valid, input heading, input restart, output ready);
endinterface

interface hpd_out_if import hpd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      clipped;

  modport source (output valid, output left_drive, output right_drive, output clipped,
                  input ready);
  modport sink   (input valid, input left_drive, input right_drive, input clipped,
                  output ready);
endinterface

### rtl/hpd_cfg_regs.sv
`timescale 1ns / 1ps
module hpd_cfg_regs import hpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TARGET:  cfg_nxt.target_heading = cfg_pwdata[HEADING_W-1:0];
        REG_GAIN_P:  cfg_nxt.gain_p         = cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:  cfg_nxt.gain_i         = cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:  cfg_nxt.gain_d         = cfg_pwdata[GAIN_W-1:0];
        REG_CURVE_F: cfg_nxt.curve_factor   = cfg_pwdata[CF_W-1:0];
        REG_CURVE_M: cfg_nxt.curve_mode     = cfg_pwdata[0];
        REG_GO_FWD:  cfg_nxt.go_forward     = cfg_pwdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET:  cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.target_heading));
      REG_GAIN_P:  cfg_prdata = CFG_DATA_W'(cfg_r.gain_p);
      REG_GAIN_I:  cfg_prdata = CFG_DATA_W'(cfg_r.gain_i);
      REG_GAIN_D:  cfg_prdata = CFG_DATA_W'(cfg_r.gain_d);
      REG_CURVE_F: cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.curve_factor));
      REG_CURVE_M: cfg_prdata = CFG_DATA_W'(cfg_r.curve_mode);
      REG_GO_FWD:  cfg_prdata = CFG_DATA_W'(cfg_r.go_forward);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading <= '0;
      cfg_r.gain_p         <= GAIN_W'(269);
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= GAIN_W'(38);
      cfg_r.curve_factor   <= CF_W'(256);
      cfg_r.curve_mode     <= 1'b0;
      cfg_r.go_forward     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/hpd_ctrl.sv
`timescale 1ns / 1ps
module hpd_ctrl import hpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_POW  = 4'b0100,
    ST_DRV  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_POW;
      end
      ST_POW: begin
        cmd.pow   = 1'b1;
        state_nxt = ST_DRV;
      end
      ST_DRV: begin
        if (!out_valid_r || out_ready) begin
          cmd.drv   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.drv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/hpd_datapath.sv
`timescale 1ns / 1ps
module hpd_datapath import hpd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  input  cmd_t                        cmd,
  input  logic signed [HEADING_W-1:0] heading,
  input  logic                        restart,
  output logic signed [DRIVE_W-1:0]   left_drive,
  output logic signed [DRIVE_W-1:0]   right_drive,
  output logic                        clipped
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] val;
    logic                      clip;
  } sat_t;

  function automatic sat_t sat_drive(input logic signed [RSH_W-1:0] v);
    sat_t r;
    r.clip = 1'b1;
    if (v > RSH_W'(DRIVE_MAX)) begin
      r.val = DRIVE_W'(DRIVE_MAX);
    end else if (v < -RSH_W'(DRIVE_MAX)) begin
      r.val = -DRIVE_W'(DRIVE_MAX);
    end else begin
      r.val  = v[DRIVE_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  logic signed [ERR_W-1:0]   last_error_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [TP_W-1:0]    tp_r;
  logic signed [TI_W-1:0]    ti_r;
  logic signed [TD_W-1:0]    td_r;
  logic signed [PWR_W-1:0]   power_r;
  logic signed [DRIVE_W-1:0] left_r;
  logic signed [DRIVE_W-1:0] right_r;
  logic                      clip_r;

  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [ERR_W-1:0]   last_eff;
  logic signed [SUM_W-1:0]   sum_eff;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [TOT_W-1:0]   total;
  logic signed [PW_W:0]      pw_dir;
  logic signed [PWR_W-1:0]   power_nxt;
  logic signed [RPROD_W-1:0] rprod;
  sat_t                      left_s;
  sat_t                      right_s;

  // error and history update at the accept edge
  always_comb begin
    err_nxt  = ERR_W'(cfg.target_heading) - ERR_W'(heading);
    last_eff = restart ? '0 : last_error_r;
    sum_eff  = restart ? '0 : sum_r;
    sum_wide = (SUM_W+1)'(sum_eff) + (SUM_W+1)'(err_nxt);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  // power: floor shift, direction, limit
  always_comb begin
    total  = TOT_W'(tp_r) + TOT_W'(ti_r) + TOT_W'(td_r);
    pw_dir = cfg.go_forward ? (PW_W+1)'($signed(total[TOT_W-1:PSHIFT]))
                            : -(PW_W+1)'($signed(total[TOT_W-1:PSHIFT]));
    if (pw_dir > (PW_W+1)'(PWR_LIM)) begin
      power_nxt = PWR_W'(PWR_LIM);
    end else if (pw_dir < -(PW_W+1)'(PWR_LIM)) begin
      power_nxt = -PWR_W'(PWR_LIM);
    end else begin
      power_nxt = pw_dir[PWR_W-1:0];
    end
  end

  // drive stage
  always_comb begin
    rprod   = RPROD_W'(power_r) * RPROD_W'(cfg.curve_factor);
    left_s  = sat_drive(RSH_W'(power_r));
    right_s = sat_drive(rprod[RPROD_W-1:RSHIFT]);
    if (!cfg.curve_mode) begin
      right_s.val  = -left_s.val;
      right_s.clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      sum_r        <= '0;
    end else if (cmd.load) begin
      last_error_r <= err_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= err_nxt;
      diff_r <= DIFF_W'(err_nxt) - DIFF_W'(last_eff);
    end
    if (cmd.mul) begin
      tp_r <= TP_W'($signed({1'b0, cfg.gain_p})) * TP_W'(err_r);
      ti_r <= TI_W'($signed({1'b0, cfg.gain_i})) * TI_W'(sum_r);
      td_r <= TD_W'($signed({1'b0, cfg.gain_d})) * TD_W'(diff_r);
    end
    if (cmd.pow) begin
      power_r <= power_nxt;
    end
    if (cmd.drv) begin
      left_r  <= left_s.val;
      right_r <= right_s.val;
      clip_r  <= left_s.clip | right_s.clip;
    end
  end

  assign left_drive  = left_r;
  assign right_drive = right_r;
  assign clipped     = clip_r;

endmodule

### rtl/heading_pid_drive.sv
`timescale 1ns / 1ps
// Discrete PID heading controller driving a two-sided base. A transaction runs in
// order: the accept edge forms the error and updates the error sum and last error,
// then the three gain products, then the summed and shifted power, and then the
// curve-factor multiply and drive saturation, held off while the output stalls. The
// sequencing controller takes a new transaction only once the previous one has
// reached the output register; a result waiting there does not block the next
// transaction until that one reaches the drive stage. Configuration sits on an APB
// port, register i at byte address 4*i; write it only while no transaction is open.
module heading_pid_drive import hpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hpd_in_if.sink                in_s,
  hpd_out_if.source             out_s,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;

  hpd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .cmd       (cmd)
  );

  hpd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .heading     (in_s.heading),
    .restart     (in_s.restart),
    .left_drive  (out_s.left_drive),
    .right_drive (out_s.right_drive),
    .clipped     (out_s.clipped)
  );

endmodule

### rtl/hpd_checker.sv
`timescale 1ns / 1ps
module hpd_checker import hpd_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] left_drive,
  input logic signed [DRIVE_W-1:0] right_drive,
  input logic                      clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(left_drive) && $stable(right_drive)
      && $stable(clipped))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("transaction accepted while one is in flight");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> left_drive != -DRIVE_W'(128) && right_drive != -DRIVE_W'(128))
    else $error("drive outside saturation range");

endmodule

bind heading_pid_drive hpd_checker u_hpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_s.valid),
  .in_ready    (in_s.ready),
  .out_valid   (out_s.valid),
  .out_ready   (out_s.ready),
  .left_drive  (out_s.left_drive),
  .right_drive (out_s.right_drive),
  .clipped     (out_s.clipped)
);

### tb/tb_heading_pid_drive.sv
`timescale 1ns / 1ps
module tb_heading_pid_drive;
  import hpd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [2:0] IDX_UNMAPPED = 3'd7;
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint HD_HI  = (longint'(1) <<< (HEADING_W - 1)) - 1;
  localparam longint HD_LO  = -HD_HI - 1;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic                      clip;
  } drive_t;

  typedef struct packed {
    logic                        is_cfg;
    logic [2:0]                  idx;
    logic [31:0]                 val;
    logic signed [HEADING_W-1:0] hd;
    logic                        rs;
    logic                        lit;
    logic signed [DRIVE_W-1:0]   l;
    logic signed [DRIVE_W-1:0]   r;
    logic                        c;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  hpd_in_if  in_if ();
  hpd_out_if out_if ();

  heading_pid_drive u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (in_if),
    .out_s       (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the register file and controller history
  logic signed [HEADING_W-1:0] tgt_hd;
  logic [GAIN_W-1:0]           kp, ki, kd;
  logic signed [CF_W-1:0]      cf;
  logic                        curve_on, fwd_on;
  longint                      prev_err, err_acc;

  drive_t    pending_drive[$];
  plan_row_t plan[$];
  int        send_idle_pct, recv_idle_pct, errors, stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat_drive(longint v, inout bit clip);
    if (v > DRIVE_MAX) begin
      clip = 1'b1;
      return DRIVE_MAX;
    end
    if (v < -DRIVE_MAX) begin
      clip = 1'b1;
      return -DRIVE_MAX;
    end
    return v;
  endfunction

  function automatic drive_t pid_step(logic signed [HEADING_W-1:0] hd, logic rs);
    longint err, power, lft, rgt;
    bit     clip;
    drive_t d;
    clip = 1'b0;
    if (rs) begin
      prev_err = 0;
      err_acc  = 0;
    end
    err = longint'(tgt_hd) - longint'(hd);
    err_acc += err;
    if (err_acc > SUM_HI) err_acc = SUM_HI;
    else if (err_acc < SUM_LO) err_acc = SUM_LO;
    power = (longint'(kp) * err + longint'(ki) * err_acc
             + longint'(kd) * (err - prev_err)) >>> 12;
    prev_err = err;
    if (!fwd_on) power = -power;
    lft = sat_drive(power, clip);
    if (curve_on) rgt = sat_drive((power * longint'(cf)) >>> 8, clip);
    else rgt = -lft;
    d.left  = lft[DRIVE_W-1:0];
    d.right = rgt[DRIVE_W-1:0];
    d.clip  = clip;
    return d;
  endfunction

  function automatic plan_row_t set_reg(logic [2:0] idx, logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic plan_row_t sample(logic signed [HEADING_W-1:0] hd, logic rs);
    plan_row_t row;
    row = '0;
    row.hd = hd;
    row.rs = rs;
    return row;
  endfunction

  function automatic plan_row_t sample_lit(logic signed [HEADING_W-1:0] hd, logic rs,
                                           logic signed [DRIVE_W-1:0] l,
                                           logic signed [DRIVE_W-1:0] r, logic c);
    plan_row_t row;
    row = sample(hd, rs);
    row.lit = 1'b1;
    row.l = l;
    row.r = r;
    row.c = c;
    return row;
  endfunction

  function automatic logic [31:0] pick_cfg(logic [2:0] idx);
    logic [31:0] v;
    int          roll;
    roll = $urandom_range(7);
    v = $urandom();
    case (idx)
      REG_TARGET: begin
        if (roll == 0) v = 32'h0007_FFFF;
        else if (roll == 1) v = 32'h0008_0000;
        else if (roll < 5) v = $urandom_range(8000) - 4000;
      end
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
        if (roll == 0) v = 32'd0;
        else if (roll == 1) v = 32'h0000_FFFF;
        else if (roll < 6) v = $urandom_range(1023);
      end
      REG_CURVE_F: begin
        if (roll == 0) v = 32'hFFFF_FE00;
        else if (roll == 1) v = 32'd512;
        else if (roll < 5) v = $urandom_range(1024) - 512;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report(string what, int want_v, int got_v);
    errors++;
    $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  task automatic send_sample(logic signed [HEADING_W-1:0] hd, logic rs, logic lit,
                             drive_t lit_exp);
    drive_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.heading <= hd;
    in_if.restart <= rs;
    do @(posedge clk); while (!in_if.ready);
    d = pid_step(hd, rs);
    pending_drive.push_back(lit ? lit_exp : d);
  endtask

  // drain all open transactions before touching the register file
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_TARGET:  tgt_hd   = val[HEADING_W-1:0];
      REG_GAIN_P:  kp       = val[GAIN_W-1:0];
      REG_GAIN_I:  ki       = val[GAIN_W-1:0];
      REG_GAIN_D:  kd       = val[GAIN_W-1:0];
      REG_CURVE_F: cf       = val[CF_W-1:0];
      REG_CURVE_M: curve_on = val[0];
      REG_GO_FWD:  fwd_on   = val[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure();
    settle();
    for (int i = 0; i <= REG_GO_FWD; i++) write_reg(3'(i), pick_cfg(3'(i)));
  endtask

  // bursts of turns converging on the target, mixed with noise bursts
  task automatic run_turns(int n);
    int     sent, burst;
    longint hd;
    bit     noisy;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(2) == 0) reconfigure();
      burst = $urandom_range(60, 5);
      noisy = ($urandom_range(9) >= 7);
      hd = int'($urandom_range(400)) - 200;
      for (int k = 0; k < burst; k++) begin
        if (noisy) begin
          send_sample(HEADING_W'($urandom()), $urandom_range(9) < 3, 1'b0, '0);
        end else begin
          hd += (longint'(tgt_hd) - hd) / int'($urandom_range(8, 2))
                + int'($urandom_range(40)) - 20;
          if (hd > HD_HI) hd = HD_HI;
          else if (hd < HD_LO) hd = HD_LO;
          send_sample(hd[HEADING_W-1:0], k == 0 || $urandom_range(99) < 2, 1'b0, '0);
        end
      end
      sent += burst;
    end
  endtask

  initial begin
    drive_t want;
    out_if.ready <= 1'b0;
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_drive.size() == 0) begin
          errors++;
          $display("%0t result with no transaction pending: left %0d right %0d clipped %0d",
                   $time, out_if.left_drive, out_if.right_drive, out_if.clipped);
        end else begin
          want = pending_drive.pop_front();
          if (out_if.left_drive !== want.left)
            report("left_drive", want.left, out_if.left_drive);
          if (out_if.right_drive !== want.right)
            report("right_drive", want.right, out_if.right_drive);
          if (out_if.clipped !== want.clip)
            report("clipped", want.clip, out_if.clipped);
        end
      end
      if ((in_if.valid && in_if.ready) || (rst_n && out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.heading <= '0;
    in_if.restart <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    errors   = 0;
    tgt_hd   = '0;
    kp       = 16'd269;
    ki       = 16'd0;
    kd       = 16'd38;
    cf       = 11'sd256;
    curve_on = 1'b0;
    fwd_on   = 1'b1;
    prev_err = 0;
    err_acc  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan = '{
      sample_lit(0, 1'b1, 0, 0, 1'b0),
      sample_lit(-524288, 1'b1, 127, -127, 1'b1),
      sample_lit(524287, 1'b1, -127, 127, 1'b1),
      sample_lit(16, 1'b1, -2, 2, 1'b0),
      sample(16, 1'b0),
      sample(-40, 1'b0),
      set_reg(REG_GO_FWD, 32'd0),
      sample(-40, 1'b0),
      sample(100, 1'b1),
      set_reg(REG_GO_FWD, 32'd1),
      set_reg(REG_CURVE_M, 32'd1),
      set_reg(REG_CURVE_F, 32'd512),
      sample(-300, 1'b1),
      set_reg(REG_CURVE_F, 32'h0000_0400),
      sample(-300, 1'b0),
      set_reg(REG_CURVE_F, 32'h0000_03FF),
      sample(200, 1'b0),
      set_reg(REG_CURVE_F, 32'hFFFF_FE00),
      sample(-300, 1'b1),
      set_reg(REG_CURVE_F, 32'd0),
      sample(-300, 1'b1),
      set_reg(IDX_UNMAPPED, 32'hFFFF_FFFF),
      sample(-100, 1'b1),
      set_reg(REG_GAIN_P, 32'h0000_FFFF),
      set_reg(REG_GAIN_I, 32'h0000_FFFF),
      set_reg(REG_GAIN_D, 32'h0000_FFFF),
      set_reg(REG_TARGET, 32'h0007_FFFF),
      sample(-524288, 1'b1),
      sample(-524288, 1'b0),
      set_reg(REG_TARGET, 32'h0008_0000),
      sample(524287, 1'b1),
      sample(0, 1'b0),
      set_reg(REG_GAIN_P, 32'd0),
      set_reg(REG_GAIN_D, 32'd0),
      set_reg(REG_GAIN_I, 32'd1),
      set_reg(REG_TARGET, 32'd0),
      set_reg(REG_CURVE_M, 32'd0),
      sample(4096, 1'b1),
      sample(-8192, 1'b0),
      set_reg(REG_GAIN_P, 32'd269),
      set_reg(REG_GAIN_I, 32'd0),
      set_reg(REG_GAIN_D, 32'd38),
      set_reg(REG_CURVE_F, 32'd256),
      sample(0, 1'b1)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].hd, plan[i].rs, plan[i].lit, {plan[i].l, plan[i].r, plan[i].c});
      end
    end

    send_idle_pct = 26;
    recv_idle_pct = 82;
    run_turns(560);
    send_idle_pct = 82;
    recv_idle_pct = 26;
    run_turns(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_turns(550);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
